>>> sv/b64e_pkg.sv
// shared types, constants and a helper function for the base64 stream encoder
`default_nettype none
package b64e_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CHAR_W   = 7;
    localparam int unsigned SEXTET_W = 6;
    localparam int unsigned LEFT_W   = 4;
    localparam int unsigned MAX_CHARS = 4;
    localparam int unsigned IDX_W    = 2;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_ONE   = 2'd1,
        PH_TWO   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
        logic [IDX_W-1:0]                 last_idx;
        logic                             fin;
    } t_job;

    function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
        logic [CHAR_W-1:0] w;
        w = {1'b0, v};
        if (v < 6'd26) begin
            sextet_char = w + 7'd65;
        end else if (v < 6'd52) begin
            sextet_char = w + 7'd71;
        end else if (v < 6'd62) begin
            sextet_char = w - 7'd4;
        end else if (v == 6'd62) begin
            sextet_char = 7'h2B;
        end else begin
            sextet_char = 7'h2F;
        end
    endfunction

endpackage
`default_nettype wire

>>> sv/b64e_front.sv
// front end: tracks group phase and leftover bits, turns each byte into a character job
`default_nettype none
module b64e_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [b64e_pkg::BYTE_W-1:0]   i_data_byte,
    input  wire logic                          i_final_byte,
    output b64e_pkg::t_job                     o_job
);
    import b64e_pkg::*;

    t_phase            r_phase, n_phase;
    logic [LEFT_W-1:0] r_left,  n_left;

    always_comb begin
        o_job          = '0;
        o_job.fin      = i_final_byte;
        o_job.chars[2] = PAD_CHAR;
        o_job.chars[3] = PAD_CHAR;
        n_phase        = PH_START;
        n_left         = '0;
        case (r_phase)
            PH_ONE: begin
                o_job.chars[0] = sextet_char({r_left[1:0], i_data_byte[7:4]});
                if (i_final_byte) begin
                    o_job.chars[1] = sextet_char({i_data_byte[3:0], 2'b00});
                    o_job.last_idx = 2'd2;
                end else begin
                    o_job.last_idx = 2'd0;
                    n_phase        = PH_TWO;
                    n_left         = i_data_byte[3:0];
                end
            end
            PH_TWO: begin
                o_job.chars[0] = sextet_char({r_left, i_data_byte[7:6]});
                o_job.chars[1] = sextet_char(i_data_byte[5:0]);
                o_job.last_idx = 2'd1;
            end
            default: begin
                o_job.chars[0] = sextet_char(i_data_byte[7:2]);
                if (i_final_byte) begin
                    o_job.chars[1] = sextet_char({i_data_byte[1:0], 4'b0000});
                    o_job.last_idx = 2'd3;
                end else begin
                    o_job.last_idx = 2'd0;
                    n_phase        = PH_ONE;
                    n_left         = {2'b00, i_data_byte[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_left  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule
`default_nettype wire

>>> sv/b64e_queue.sv
// short job queue between front and back ends
`default_nettype none
module b64e_queue #(
    parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire b64e_pkg::t_job i_job,
    input  wire logic           i_rd,
    output b64e_pkg::t_job      o_job,
    output logic                o_full,
    output logic                o_empty
);
    import b64e_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/b64e_back.sv
// back end: moves jobs to the output register, one char per cycle if popped
`default_nettype none
module b64e_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire b64e_pkg::t_job                i_job,
    input  wire logic                          i_job_empty,
    output logic                               o_job_rd,
    input  wire logic                          i_pop,
    output logic                               o_empty,
    output logic [b64e_pkg::CHAR_W-1:0]        o_out_char,
    output logic                               o_end_of_message
);
    import b64e_pkg::*;

    logic [IDX_W-1:0]  r_idx;
    logic              r_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_eom;
    logic              load;
    logic              at_last;

    assign load     = (!r_valid || i_pop) && !i_job_empty;
    assign at_last  = (r_idx == i_job.last_idx);
    assign o_job_rd = load && at_last;

    assign o_empty          = !r_valid;
    assign o_out_char       = r_char;
    assign o_end_of_message = r_eom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= at_last ? '0 : r_idx + 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= i_job.chars[r_idx];
            r_eom  <= i_job.fin && at_last;
        end
    end

endmodule
`default_nettype wire

>>> sv/base64_stream_encoder_top.sv
// a byte's job goes into the job queue, then its characters into the output register
// throughput: one byte per cycle in while the queue has room, one char per cycle out on pop
// a byte gives one or two output characters mid-group and up to four on a final byte
// so the output side sets the sustained rate, four characters per group of three bytes
// a job queue of QUEUE_DEPTH entries lets the byte side run ahead of the character side
// reset: synchronous active low, clears group phase, queue and the output register's valid flag
`default_nettype none
module base64_stream_encoder_top #(
    parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [b64e_pkg::BYTE_W-1:0]   i_data_byte,
    input  wire logic                          i_final_byte,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [b64e_pkg::CHAR_W-1:0]        o_out_char,
    output logic                               o_end_of_message
);
    import b64e_pkg::*;

    t_job front_job, queue_job;
    logic accept, q_empty, q_rd;

    assign accept = push && !full;

    b64e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_job        (front_job)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_job   (front_job),
        .i_rd    (q_rd),
        .o_job   (queue_job),
        .o_full  (full),
        .o_empty (q_empty)
    );

    b64e_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job            (queue_job),
        .i_job_empty      (q_empty),
        .o_job_rd         (q_rd),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_out_char       (o_out_char),
        .o_end_of_message (o_end_of_message)
    );

endmodule
`default_nettype wire
